// ----- rtl/ogpd_pkg.sv -----
`timescale 1ns / 1ps

package ogpd_pkg;

  localparam int unsigned TBL_DEPTH  = 255;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned TDATA_W    = 112;

  localparam logic [7:0] LACE_FULL = 8'hFF;

  // header byte positions
  localparam logic [4:0] HDR_CAP_LAST  = 5'd3;
  localparam logic [4:0] HDR_GRAN_LO   = 5'd6;
  localparam logic [4:0] HDR_GRAN_HI   = 5'd13;
  localparam logic [4:0] HDR_SEQ_LO    = 5'd18;
  localparam logic [4:0] HDR_SEQ_HI    = 5'd21;
  localparam logic [4:0] HDR_SEG_COUNT = 5'd26;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_CAPTURE  = 2'd1;
  localparam logic [1:0] ERR_SEQUENCE = 2'd2;
  localparam logic [1:0] ERR_TRUNC    = 2'd3;

  // one stored lacing value; zb marks a zero-length segment just before it
  typedef struct packed {
    logic       zb;
    logic [7:0] len;
  } lace_t;

  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        packet_end;
    logic [63:0] page_granule;
    logic [31:0] page_number;
    logic [1:0]  error_code;
  } result_t;

  function automatic logic [7:0] capture_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h4F; // O
      2'd1:    c = 8'h67; // g
      2'd2:    c = 8'h67; // g
      default: c = 8'h53; // S
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/ogpd_front.sv -----
`timescale 1ns / 1ps

module ogpd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  logic [7:0]        data_byte,
  input  logic              stream_end,
  output logic              res_valid,
  output ogpd_pkg::result_t res
);

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_TABLE   = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;

  logic [1:0]  phase_r, phase_nxt;
  logic [4:0]  hdr_idx_r, hdr_idx_nxt;
  logic [63:0] gran_r, gran_nxt;
  logic [31:0] seq_r, seq_nxt;
  logic [31:0] exp_r, exp_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic [7:0]  tbl_idx_r, tbl_idx_nxt;
  logic [7:0]  n_r, n_nxt;
  logic        zrun_r, zrun_nxt;
  logic        trail_r, trail_nxt;
  ogpd_pkg::lace_t e0_r, e0_nxt, e1_r, e1_nxt;
  ogpd_pkg::lace_t nxt_r, nxt_nxt;
  logic        nxt_ok_r, nxt_ok_nxt;
  logic [7:0]  cur_len_r, cur_len_nxt;
  logic [7:0]  rem_r, rem_nxt;
  logic [7:0]  cur_idx_r, cur_idx_nxt;
  logic        open_r, open_nxt;
  logic        err_r, err_nxt;
  logic [1:0]  code_r, code_nxt;

  // compacted segment table: nonzero lacing values only
  ogpd_pkg::lace_t tbl_mem [ogpd_pkg::TBL_DEPTH];
  ogpd_pkg::lace_t tbl_rd_r;
  logic            tbl_we;
  logic [7:0]      tbl_wa;
  ogpd_pkg::lace_t tbl_wd;
  logic [8:0]      rd_addr9;
  logic            tbl_re;

  logic            emit, pv, pend;
  logic            b_nz, seg_end, zf, tbl_end, closes;
  logic [7:0]      n_fin;
  ogpd_pkg::lace_t first_e, second_e;

  always_comb begin
    phase_nxt   = phase_r;
    hdr_idx_nxt = hdr_idx_r;
    gran_nxt    = gran_r;
    seq_nxt     = seq_r;
    exp_nxt     = exp_r;
    cnt_nxt     = cnt_r;
    tbl_idx_nxt = tbl_idx_r;
    n_nxt       = n_r;
    zrun_nxt    = zrun_r;
    trail_nxt   = trail_r;
    e0_nxt      = e0_r;
    e1_nxt      = e1_r;
    nxt_nxt     = nxt_r;
    nxt_ok_nxt  = nxt_ok_r;
    cur_len_nxt = cur_len_r;
    rem_nxt     = rem_r;
    cur_idx_nxt = cur_idx_r;
    open_nxt    = open_r;
    err_nxt     = err_r;
    code_nxt    = code_r;
    emit        = 1'b0;
    pv          = 1'b0;
    pend        = 1'b0;
    tbl_we      = 1'b0;
    b_nz        = (data_byte != 8'd0);
    tbl_wa      = n_r;
    tbl_wd      = '{zb: zrun_r, len: data_byte};
    n_fin       = n_r + {7'd0, b_nz};
    first_e     = (n_r == 8'd0) ? tbl_wd : e0_r;
    second_e    = (n_r == 8'd1) ? tbl_wd : e1_r;
    seg_end     = (rem_r == 8'd1);
    zf          = nxt_ok_r ? nxt_r.zb : trail_r;
    tbl_end     = (({1'b0, tbl_idx_r} + 9'd1) >= {1'b0, cnt_r});
    closes      = open_r && ((n_fin == 8'd0) || first_e.zb);

    if (acc && !err_r) begin
      case (phase_r)
        PH_HEADER: begin
          if (hdr_idx_r <= ogpd_pkg::HDR_CAP_LAST) begin
            if (data_byte != ogpd_pkg::capture_char(hdr_idx_r[1:0])) begin
              err_nxt  = 1'b1;
              code_nxt = ogpd_pkg::ERR_CAPTURE;
            end
          end else if (hdr_idx_r >= ogpd_pkg::HDR_GRAN_LO &&
                       hdr_idx_r <= ogpd_pkg::HDR_GRAN_HI) begin
            gran_nxt = {data_byte, gran_r[63:8]};
          end else if (hdr_idx_r >= ogpd_pkg::HDR_SEQ_LO &&
                       hdr_idx_r <= ogpd_pkg::HDR_SEQ_HI) begin
            seq_nxt = {data_byte, seq_r[31:8]};
            if (hdr_idx_r == ogpd_pkg::HDR_SEQ_HI) begin
              if (seq_nxt != exp_r) begin
                err_nxt  = 1'b1;
                code_nxt = ogpd_pkg::ERR_SEQUENCE;
              end else begin
                exp_nxt = exp_r + 32'd1;
              end
            end
          end
          if (hdr_idx_r >= ogpd_pkg::HDR_SEG_COUNT) begin
            cnt_nxt     = data_byte;
            hdr_idx_nxt = 5'd0;
            tbl_idx_nxt = 8'd0;
            n_nxt       = 8'd0;
            zrun_nxt    = 1'b0;
            phase_nxt   = b_nz ? PH_TABLE : PH_HEADER;
          end else begin
            hdr_idx_nxt = hdr_idx_r + 5'd1;
          end
        end
        PH_TABLE: begin
          tbl_we      = b_nz;
          tbl_idx_nxt = tbl_idx_r + 8'd1;
          zrun_nxt    = !b_nz;
          n_nxt       = n_fin;
          if (b_nz && n_r == 8'd0) e0_nxt = tbl_wd;
          if (b_nz && n_r == 8'd1) e1_nxt = tbl_wd;
          if (tbl_end) begin
            if (closes) begin
              emit     = 1'b1;
              pend     = 1'b1;
              open_nxt = 1'b0;
            end
            if (n_fin == 8'd0) begin
              phase_nxt   = PH_HEADER;
              hdr_idx_nxt = 5'd0;
            end else begin
              phase_nxt   = PH_PAYLOAD;
              cur_len_nxt = first_e.len;
              rem_nxt     = first_e.len;
              cur_idx_nxt = 8'd0;
              nxt_nxt     = second_e;
              nxt_ok_nxt  = (n_fin >= 8'd2);
              trail_nxt   = !b_nz;
            end
          end
        end
        PH_PAYLOAD: begin
          emit     = 1'b1;
          pv       = 1'b1;
          open_nxt = 1'b1;
          rem_nxt  = rem_r - 8'd1;
          if (seg_end) begin
            pend     = (cur_len_r != ogpd_pkg::LACE_FULL) || zf;
            open_nxt = (cur_len_r == ogpd_pkg::LACE_FULL) && !zf;
            if (nxt_ok_r) begin
              cur_len_nxt = nxt_r.len;
              rem_nxt     = nxt_r.len;
              cur_idx_nxt = cur_idx_r + 8'd1;
              nxt_nxt     = tbl_rd_r;
              nxt_ok_nxt  = (({1'b0, cur_idx_r} + 9'd2) < {1'b0, n_r});
            end else begin
              phase_nxt   = PH_HEADER;
              hdr_idx_nxt = 5'd0;
            end
          end
        end
        default: begin
          phase_nxt   = PH_HEADER;
          hdr_idx_nxt = 5'd0;
        end
      endcase

      if (stream_end && !err_nxt &&
          (phase_nxt != PH_HEADER || hdr_idx_nxt != 5'd0 || open_nxt)) begin
        err_nxt  = 1'b1;
        code_nxt = ogpd_pkg::ERR_TRUNC;
      end
    end

    res_valid         = emit || err_nxt;
    res.payload_valid = pv;
    res.payload_byte  = pv ? data_byte : 8'd0;
    res.packet_end    = pend;
    res.page_granule  = gran_nxt;
    res.page_number   = seq_nxt;
    res.error_code    = code_nxt;
  end

  // keeps tbl_rd_r equal to entry cur_idx_r + 2
  assign rd_addr9 = {1'b0, cur_idx_nxt} + 9'd2;
  assign tbl_re   = (rd_addr9 < 9'(ogpd_pkg::TBL_DEPTH));

  always_ff @(posedge clk) begin
    if (tbl_we) tbl_mem[tbl_wa] <= tbl_wd;
    if (tbl_re) begin
      tbl_rd_r <= (tbl_we && tbl_wa == rd_addr9[7:0]) ? tbl_wd : tbl_mem[rd_addr9[7:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      hdr_idx_r <= 5'd0;
      gran_r    <= 64'd0;
      seq_r     <= 32'd0;
      exp_r     <= 32'd0;
      cnt_r     <= 8'd0;
      tbl_idx_r <= 8'd0;
      n_r       <= 8'd0;
      zrun_r    <= 1'b0;
      trail_r   <= 1'b0;
      e0_r      <= '0;
      e1_r      <= '0;
      nxt_r     <= '0;
      nxt_ok_r  <= 1'b0;
      cur_len_r <= 8'd0;
      rem_r     <= 8'd0;
      cur_idx_r <= 8'd0;
      open_r    <= 1'b0;
      err_r     <= 1'b0;
      code_r    <= ogpd_pkg::ERR_NONE;
    end else begin
      phase_r   <= phase_nxt;
      hdr_idx_r <= hdr_idx_nxt;
      gran_r    <= gran_nxt;
      seq_r     <= seq_nxt;
      exp_r     <= exp_nxt;
      cnt_r     <= cnt_nxt;
      tbl_idx_r <= tbl_idx_nxt;
      n_r       <= n_nxt;
      zrun_r    <= zrun_nxt;
      trail_r   <= trail_nxt;
      e0_r      <= e0_nxt;
      e1_r      <= e1_nxt;
      nxt_r     <= nxt_nxt;
      nxt_ok_r  <= nxt_ok_nxt;
      cur_len_r <= cur_len_nxt;
      rem_r     <= rem_nxt;
      cur_idx_r <= cur_idx_nxt;
      open_r    <= open_nxt;
      err_r     <= err_nxt;
      code_r    <= code_nxt;
    end
  end

`ifndef SYNTHESIS
  a_payload_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAYLOAD) |-> (rem_r != 8'd0))
    else $error("payload phase with no bytes left in segment");
  a_payload_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAYLOAD) |-> (cur_idx_r < n_r))
    else $error("segment index past stored entries");
  a_err_result: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && err_r) |-> (res_valid && res.error_code != ogpd_pkg::ERR_NONE))
    else $error("latched error without result");
`endif

endmodule

// ----- rtl/ogpd_fifo.sv -----
`timescale 1ns / 1ps

module ogpd_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ogpd_pkg::result_t push_data,
  input  logic              pop,
  output logic              full,
  output logic              not_empty,
  output ogpd_pkg::result_t head
);

  ogpd_pkg::result_t               mem_r [ogpd_pkg::FIFO_DEPTH];
  logic [ogpd_pkg::FIFO_AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [ogpd_pkg::FIFO_AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [ogpd_pkg::FIFO_AW:0]      count_r, count_nxt;
  logic                            do_push, do_pop;

  assign full      = (count_r == (ogpd_pkg::FIFO_AW + 1)'(ogpd_pkg::FIFO_DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + {{ogpd_pkg::FIFO_AW{1'b0}}, do_push}
                         - {{ogpd_pkg::FIFO_AW{1'b0}}, do_pop};
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("item pushed into full queue");
  a_count_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("empty queue with unequal pointers");
`endif

endmodule

// ----- rtl/ogpd_back.sv -----
`timescale 1ns / 1ps

module ogpd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  ogpd_pkg::result_t q_head,
  output logic              q_pop,
  output logic              out_valid,
  output ogpd_pkg::result_t out_res,
  input  logic              out_ready
);

  logic              valid_r, valid_nxt;
  ogpd_pkg::result_t res_r;

  assign q_pop     = q_valid && (!valid_r || out_ready);
  assign valid_nxt = q_pop || (valid_r && !out_ready);
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (q_pop) res_r <= q_head;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

endmodule

// ----- rtl/ogg_page_deframer.sv -----
`timescale 1ns / 1ps
// A result goes into the result queue, then into the output register that drives out_*.
// Throughput: one byte per cycle in every phase (header, segment table, payload) while
// the result queue is not full; the segment table memory is read one entry ahead so
// back-to-back short segments keep pace. A four-entry result queue decouples the parser
// from the output register. Reset: synchronous, active low; clears all parser and queue
// control state. The segment table memory is not cleared and needs no clearing pass.

module ogg_page_deframer (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [7:0]                   in_tdata,  // data_byte
  input  logic                         in_tlast,  // stream_end
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // payload_byte[7:0], page_granule[71:8], page_number[103:72], error_code[105:104]
  output logic [ogpd_pkg::TDATA_W-1:0] out_tdata,
  output logic                         out_tlast, // packet_end
  output logic                         out_tuser  // payload_valid
);

  logic              acc;
  logic              res_valid;
  ogpd_pkg::result_t res;
  logic              q_full, q_not_empty, q_pop;
  ogpd_pkg::result_t q_head;
  ogpd_pkg::result_t out_res;

  assign in_tready = !q_full;
  assign acc       = in_tvalid && in_tready;

  ogpd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .data_byte  (in_tdata),
    .stream_end (in_tlast),
    .res_valid  (res_valid),
    .res        (res)
  );

  ogpd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (acc && res_valid),
    .push_data (res),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  ogpd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_not_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_res   (out_res),
    .out_ready (out_tready)
  );

  assign out_tdata = {6'd0, out_res.error_code, out_res.page_number,
                      out_res.page_granule, out_res.payload_byte};
  assign out_tlast = out_res.packet_end;
  assign out_tuser = out_res.payload_valid;

endmodule
